@@ rtl/rcfd_pkg.sv @@
`default_nettype none

package rcfd_pkg;

  localparam int FRAME_BYTES      = 32;
  localparam int MAX_CHANNELS_DEF = 14;

  localparam int CH_CNT_W   = 4;
  localparam int LOST_W     = 8;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int POS_W      = 5;
  localparam int SUM_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int IDX_W      = 4;
  localparam int STATUS_W   = 2;

  localparam logic [BYTE_W-1:0]   HDR0     = 8'h20;
  localparam logic [BYTE_W-1:0]   HDR1     = 8'h40;
  localparam logic [SUM_W-1:0]    SUM_INIT = 16'hFFFF;
  localparam logic [POS_W-1:0]    SUM_END  = 5'd30;
  localparam logic [POS_W-1:0]    POS_LAST = POS_W'(FRAME_BYTES - 1);

  localparam logic [CH_CNT_W-1:0] CH_CNT_RESET     = 4'd14;
  localparam logic [LOST_W-1:0]   LOST_LIMIT_RESET = 8'd20;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_LIMIT    = 1'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_CHANNEL  = 2'd0,
    ST_CSUM_ERR = 2'd1,
    ST_LOST     = 2'd2,
    ST_ALIVE    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEND
  } state_e;

  typedef struct packed {
    logic [CH_CNT_W-1:0] channel_count;
    logic [LOST_W-1:0]   lost_limit;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/rcfd_stream_if.sv @@
`default_nettype none

interface rcfd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface rcfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  channel_index;
  logic [15:0] channel_value;
  logic        last;

  modport source (output valid, output status, output channel_index,
                  output channel_value, output last, input ready);
  modport sink   (input valid, input status, input channel_index,
                  input channel_value, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/rcfd_ram.sv @@
`default_nettype none

module rcfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 14,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/rcfd_ctrl.sv @@
`default_nettype none

module rcfd_ctrl
  import rcfd_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire cfg_t         cfg_i,
  rcfd_in_if.sink           in_i,
  rcfd_out_if.source        out_o,
  output logic              ram_we_o,
  output logic [AW-1:0]     ram_waddr_o,
  output logic [SUM_W-1:0]  ram_wdata_o,
  output logic              ram_re_o,
  output logic [AW-1:0]     ram_raddr_o,
  input  wire logic [SUM_W-1:0] ram_rdata_i
);

  localparam logic [IDX_W-1:0] MAX_CH = IDX_W'(MAX_CHANNELS);

  state_e state_q, state_d;

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [BYTE_W-1:0] low_q, low_d;
  logic [LOST_W-1:0] lost_q, lost_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  n_q, n_d;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [IDX_W-1:0]    out_index_q, out_index_d;
  logic [SUM_W-1:0]    out_value_q, out_value_d;
  logic                out_last_q, out_last_d;

  logic             slot_free;
  logic             in_xfer;
  logic             byte_xfer;
  logic             frame_good;
  logic             last_ch;
  logic [POS_W-1:0] pos_m2;
  logic [IDX_W-1:0] ch;
  logic [SUM_W-1:0] sum_sub;
  logic [SUM_W-1:0] got;
  logic [IDX_W-1:0] n_cfg;

  assign slot_free = !out_valid_q || out_o.ready;
  assign in_xfer   = in_i.valid && in_i.ready;
  assign byte_xfer = in_xfer && !in_i.kind;
  assign pos_m2    = pos_q - 5'd2;
  assign ch        = pos_m2[POS_W-1:1];
  assign sum_sub   = sum_q - {8'h00, in_i.rx_byte};
  assign got       = {in_i.rx_byte, low_q};
  assign frame_good = byte_xfer && (pos_q == POS_LAST) && (got == sum_q);
  assign last_ch   = (idx_q + 4'd1) == n_q;

  always_comb begin
    if (cfg_i.channel_count == '0) begin
      n_cfg = 4'd1;
    end else if (cfg_i.channel_count > MAX_CH) begin
      n_cfg = MAX_CH;
    end else begin
      n_cfg = cfg_i.channel_count;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (frame_good) state_d = S_READ;
      S_READ: state_d = S_SEND;
      S_SEND: if (slot_free) state_d = last_ch ? S_IDLE : S_READ;
      default: state_d = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_i.ready  = (state_q == S_IDLE) && slot_free;
    ram_re_o    = (state_q == S_READ);
    ram_raddr_o = idx_q[AW-1:0];
  end

  // frame parser
  always_comb begin
    pos_d       = pos_q;
    sum_d       = sum_q;
    low_d       = low_q;
    n_d         = n_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = ch[AW-1:0];
    ram_wdata_o = got;
    if (byte_xfer) begin
      priority if (pos_q == '0) begin
        if (in_i.rx_byte == HDR0) begin
          sum_d = SUM_INIT - {8'h00, HDR0};
          pos_d = 5'd1;
        end
      end else if (pos_q == 5'd1) begin
        if (in_i.rx_byte == HDR1) begin
          sum_d = sum_sub;
          pos_d = 5'd2;
        end else if (in_i.rx_byte == HDR0) begin
          sum_d = SUM_INIT - {8'h00, HDR0};
          pos_d = 5'd1;
        end else begin
          sum_d = SUM_INIT;
          pos_d = '0;
        end
      end else if (pos_q < SUM_END) begin
        sum_d = sum_sub;
        if (!pos_q[0]) begin
          low_d = in_i.rx_byte;
        end else if (ch < MAX_CH) begin
          ram_we_o = 1'b1;
        end
        pos_d = pos_q + 5'd1;
      end else if (pos_q < POS_LAST) begin
        low_d = in_i.rx_byte;
        pos_d = pos_q + 5'd1;
      end else begin
        pos_d = '0;
        sum_d = SUM_INIT;
        if (frame_good) begin
          n_d = n_cfg;
        end
      end
    end
  end

  // lost watch, channel index and output register
  always_comb begin
    lost_d       = lost_q;
    idx_d        = idx_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_index_d  = out_index_q;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    if (in_xfer && in_i.kind) begin
      out_valid_d = 1'b1;
      out_index_d = '0;
      out_value_d = '0;
      out_last_d  = 1'b1;
      if (cfg_i.lost_limit > lost_q) begin
        lost_d       = lost_q + 8'd1;
        out_status_d = ST_ALIVE;
      end else begin
        out_status_d = ST_LOST;
      end
    end else if (byte_xfer && (pos_q == POS_LAST)) begin
      if (frame_good) begin
        lost_d = '0;
        idx_d  = '0;
      end else begin
        out_valid_d  = 1'b1;
        out_status_d = ST_CSUM_ERR;
        out_index_d  = '0;
        out_value_d  = '0;
        out_last_d   = 1'b1;
      end
    end else if ((state_q == S_SEND) && slot_free) begin
      out_valid_d  = 1'b1;
      out_status_d = ST_CHANNEL;
      out_index_d  = idx_q;
      out_value_d  = ram_rdata_i;
      out_last_d   = last_ch;
      idx_d        = idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      sum_q       <= SUM_INIT;
      low_q       <= '0;
      lost_q      <= '0;
      idx_q       <= '0;
      n_q         <= 4'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      low_q       <= low_d;
      lost_q      <= lost_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_index_q  <= out_index_d;
    out_value_q  <= out_value_d;
    out_last_q   <= out_last_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.channel_index = out_index_q;
  assign out_o.channel_value = out_value_q;
  assign out_o.last          = out_last_q;

  a_ram_read_then_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re_o |=> state_q == S_SEND)
    else $error("channel read not followed by send");

  a_no_write_while_emitting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> state_q == S_IDLE)
    else $error("channel store written during emission");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> (n_q != '0) && (n_q <= MAX_CH) && (idx_q < n_q))
    else $error("emission count out of range");

  a_last_on_final_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q && (out_status_q == ST_CHANNEL)
      |-> out_index_q == n_q - 4'd1)
    else $error("last mark not on final channel");

endmodule

`default_nettype wire

@@ rtl/rc_frame_decoder_with_lost_watch_top.sv @@
// Output: the result of a tick or a bad-checksum frame is registered and valid at the
//   output from the cycle after the transfer.
// Throughput: after a good frame's final byte, n channels come out, each by a channel RAM
//   read, then an output load held while the output stalls; no input is taken until the
//   last channel is loaded. Otherwise one item per cycle unless the output stalls.
// Reset (asynchronous, active low): config to defaults, parser hunting for a header,
//   lost counter zero, output empty. The channel RAM is not cleared.
`default_nettype none

module rc_frame_decoder_with_lost_watch_top
  import rcfd_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  rcfd_in_if.sink                    in_i,
  rcfd_out_if.source                 out_o
);

  cfg_t cfg_q, cfg_d;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [SUM_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [SUM_W-1:0] ram_rdata;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CHANNEL_COUNT: cfg_d.channel_count = cfg_data_i[CH_CNT_W-1:0];
        REG_LOST_LIMIT:    cfg_d.lost_limit    = cfg_data_i[LOST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_count <= CH_CNT_RESET;
      cfg_q.lost_limit    <= LOST_LIMIT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rcfd_ctrl #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_i        (in_i),
    .out_o       (out_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  rcfd_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_CHANNELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

@@ bench/tb_rc_frame_decoder_with_lost_watch_top.sv @@
`timescale 1ns / 100ps

module tb_rc_frame_decoder_with_lost_watch_top;
  import rcfd_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int RANDOM_ITEMS = 100;
  localparam int NUM_CH       = MAX_CHANNELS_DEF;

  typedef enum int {
    PAT_RANDOM,
    PAT_ZERO,
    PAT_ONES,
    PAT_MIXED
  } word_pattern_e;

  typedef struct {
    status_e           status;
    logic [IDX_W-1:0]  ch_index;
    logic [15:0]       ch_value;
    logic              is_last;
  } report_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rcfd_in_if  in_if ();
  rcfd_out_if out_if ();

  rc_frame_decoder_with_lost_watch_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // decoder copy
  logic [POS_W-1:0]    parse_pos;
  logic [SUM_W-1:0]    frame_sum;
  logic [BYTE_W-1:0]   low_hold;
  logic [15:0]         word_store [NUM_CH];
  logic [LOST_W-1:0]   miss_ticks;
  logic [CH_CNT_W-1:0] cfg_channels;
  logic [LOST_W-1:0]   cfg_lost_limit;

  report_t decoded_reports [$];
  report_t head;

  int  mismatches  = 0;
  int  items_sent  = 0;
  int  ticks_sent  = 0;
  int  frames_sent = 0;
  int  reports_ok  = 0;
  int  cfg_writes  = 0;
  int  stall_left  = 0;
  bit  steady      = 1'b0;
  bit  mix_ticks   = 1'b0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void push_report(status_e st, logic [IDX_W-1:0] idx,
                                      logic [15:0] val, logic lst);
    report_t r;
    r.status   = st;
    r.ch_index = idx;
    r.ch_value = val;
    r.is_last  = lst;
    decoded_reports.push_back(r);
  endfunction

  function automatic void decode_item(logic kind, logic [BYTE_W-1:0] b);
    logic [15:0] got;
    int n;
    if (kind) begin
      if (cfg_lost_limit > miss_ticks) begin
        miss_ticks = miss_ticks + 8'd1;
        push_report(ST_ALIVE, '0, '0, 1'b1);
      end else begin
        push_report(ST_LOST, '0, '0, 1'b1);
      end
      return;
    end
    if (parse_pos == 0) begin
      if (b == HDR0) begin
        frame_sum = SUM_INIT - {8'h00, b};
        parse_pos = 5'd1;
      end
    end else if (parse_pos == 1) begin
      if (b == HDR1) begin
        frame_sum = frame_sum - {8'h00, b};
        parse_pos = 5'd2;
      end else if (b == HDR0) begin
        // restart on a fresh first header byte
        frame_sum = SUM_INIT - {8'h00, b};
        parse_pos = 5'd1;
      end else begin
        frame_sum = SUM_INIT;
        parse_pos = 5'd0;
      end
    end else if (parse_pos < SUM_END) begin
      frame_sum = frame_sum - {8'h00, b};
      if (!parse_pos[0]) low_hold = b;
      else word_store[(parse_pos - 5'd2) >> 1] = {b, low_hold};
      parse_pos = parse_pos + 5'd1;
    end else if (parse_pos < POS_LAST) begin
      low_hold  = b;
      parse_pos = parse_pos + 5'd1;
    end else begin
      got       = {b, low_hold};
      parse_pos = 5'd0;
      if (got == frame_sum) begin
        n = cfg_channels;
        if (n < 1) n = 1;
        if (n > NUM_CH) n = NUM_CH;
        for (int i = 0; i < n; i++)
          push_report(ST_CHANNEL, IDX_W'(i), word_store[i], i == n - 1);
        miss_ticks = '0;
      end else begin
        push_report(ST_CSUM_ERR, '0, '0, 1'b1);
      end
      frame_sum = SUM_INIT;
    end
  endfunction

  // Sink side: random stalls on ready
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      stall_left = gap_len();
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (decoded_reports.size() == 0) begin
        $error("result with nothing pending: status %0d index %0d value %h last %0d",
               out_if.status, out_if.channel_index, out_if.channel_value, out_if.last);
        mismatches++;
      end else begin
        head = decoded_reports.pop_front();
        if (out_if.status !== head.status) begin
          $error("status: expected %0d, actual %0d", head.status, out_if.status);
          mismatches++;
        end
        if (out_if.channel_index !== head.ch_index) begin
          $error("channel_index: expected %0d, actual %0d", head.ch_index,
                 out_if.channel_index);
          mismatches++;
        end
        if (out_if.channel_value !== head.ch_value) begin
          $error("channel_value: expected %h, actual %h", head.ch_value,
                 out_if.channel_value);
          mismatches++;
        end
        if (out_if.last !== head.is_last) begin
          $error("last: expected %0d, actual %0d", head.is_last, out_if.last);
          mismatches++;
        end
        reports_ok++;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results pending", CYCLE_LIMIT,
             decoded_reports.size());
    $display("FAILURE");
    $finish;
  end

  // Called at a clock edge; returns at the edge of the transfer.
  task automatic send_item(logic kind, logic [BYTE_W-1:0] b);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.kind    <= kind;
    in_if.rx_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    decode_item(kind, b);
    items_sent++;
    if (kind) ticks_sent++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_noise(int n);
    repeat (n)
      send_item(1'b0, ($urandom_range(0, 5) == 0) ? HDR0 : 8'($urandom_range(0, 255)));
  endtask

  task automatic send_frame(word_pattern_e pat, bit bad_sum, int len);
    logic [7:0]  fb [FRAME_BYTES];
    logic [15:0] w;
    logic [15:0] csum;
    fb[0] = HDR0;
    fb[1] = HDR1;
    for (int i = 0; i < NUM_CH; i++) begin
      case (pat)
        PAT_ZERO: w = 16'h0000;
        PAT_ONES: w = 16'hFFFF;
        PAT_MIXED: begin
          case ($urandom_range(0, 2))
            0: w = 16'h0000;
            1: w = 16'hFFFF;
            default: w = 16'($urandom_range(0, 65535));
          endcase
        end
        default: w = 16'($urandom_range(0, 65535));
      endcase
      fb[2 + 2 * i] = w[7:0];
      fb[3 + 2 * i] = w[15:8];
    end
    csum = SUM_INIT;
    for (int i = 0; i < SUM_END; i++) csum = csum - {8'h00, fb[i]};
    if (bad_sum) csum = csum ^ 16'($urandom_range(1, 65535));
    fb[30] = csum[7:0];
    fb[31] = csum[15:8];
    for (int i = 0; i < len; i++) begin
      if (mix_ticks && $urandom_range(0, 19) == 0) send_ticks(1);
      send_item(1'b0, fb[i]);
    end
    frames_sent++;
  endtask

  // Drop valid and drain the pipe before touching registers.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (decoded_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_CHANNEL_COUNT) cfg_channels = data[CH_CNT_W-1:0];
    else cfg_lost_limit = data[LOST_W-1:0];
    cfg_writes++;
    @(posedge clk_i);
  endtask

  task automatic test_defaults();
    // default limit: alive up to the limit, then lost
    send_ticks(22);
    send_frame(PAT_MIXED, 1'b0, FRAME_BYTES);
    send_ticks(1);
  endtask

  task automatic test_header_resync();
    logic [7:0] seq [8];
    seq = '{8'h00, 8'hFF, HDR1, HDR0, 8'h13, HDR1, HDR0, HDR0};
    foreach (seq[i]) send_item(1'b0, seq[i]);
    send_frame(PAT_RANDOM, 1'b0, FRAME_BYTES);
    mix_ticks = 1'b1;
    send_frame(PAT_RANDOM, 1'b0, FRAME_BYTES);
    mix_ticks = 1'b0;
  endtask

  task automatic test_checksum_error();
    send_frame(PAT_RANDOM, 1'b1, FRAME_BYTES);
    send_frame(PAT_ZERO, 1'b0, FRAME_BYTES);
  endtask

  task automatic test_channel_count();
    settle();
    cfg_write(REG_CHANNEL_COUNT, 8'd0);
    send_frame(PAT_ONES, 1'b0, FRAME_BYTES);
    settle();
    cfg_write(REG_CHANNEL_COUNT, 8'd15);
    send_frame(PAT_ZERO, 1'b0, FRAME_BYTES);
    settle();
    // upper data bits fall outside the register
    cfg_write(REG_CHANNEL_COUNT, 8'hF1);
    send_frame(PAT_RANDOM, 1'b0, FRAME_BYTES);
    settle();
    cfg_write(REG_CHANNEL_COUNT, 8'd14);
  endtask

  task automatic test_lost_limit();
    settle();
    cfg_write(REG_LOST_LIMIT, 8'd0);
    send_ticks(2);
    settle();
    // small limit: a few alive, then lost
    cfg_write(REG_LOST_LIMIT, 8'd3);
    send_ticks(5);
  endtask

  task automatic test_random();
    int start_items;
    int phase_end;
    int r;
    logic [7:0] d;
    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 4))
        0: d = 8'd0;
        1: d = 8'd1;
        2: d = 8'd14;
        3: d = 8'd15;
        default: d = 8'($urandom_range(0, 15));
      endcase
      if ($urandom_range(0, 3) == 0) d[7:4] = 4'($urandom_range(1, 15));
      cfg_write(REG_CHANNEL_COUNT, d);
      case ($urandom_range(0, 3))
        0: d = 8'd0;
        1: d = 8'd255;
        2: d = 8'($urandom_range(1, 30));
        default: d = 8'($urandom_range(0, 255));
      endcase
      cfg_write(REG_LOST_LIMIT, d);
      steady    = ($urandom_range(0, 4) == 0);
      mix_ticks = ($urandom_range(0, 2) == 0);
      phase_end = items_sent + $urandom_range(30, 60);
      while (items_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 55)
          send_frame(($urandom_range(0, 4) == 0) ? PAT_MIXED : PAT_RANDOM, 1'b0,
                     FRAME_BYTES);
        else if (r < 65)
          send_frame(PAT_RANDOM, 1'b1, FRAME_BYTES);
        else if (r < 75)
          send_frame(PAT_RANDOM, 1'b0, $urandom_range(2, FRAME_BYTES - 1));
        else if (r < 85)
          send_noise($urandom_range(1, 12));
        else
          send_ticks($urandom_range(1, 25));
      end
    end
    steady    = 1'b0;
    mix_ticks = 1'b0;
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    in_if.valid    = 1'b0;
    in_if.kind     = 1'b0;
    in_if.rx_byte  = '0;
    out_if.ready   = 1'b0;
    parse_pos      = '0;
    frame_sum      = SUM_INIT;
    low_hold       = '0;
    miss_ticks     = '0;
    cfg_channels   = CH_CNT_RESET;
    cfg_lost_limit = LOST_LIMIT_RESET;
    foreach (word_store[i]) word_store[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults();
    test_header_resync();
    test_checksum_error();
    test_channel_count();
    test_lost_limit();
    test_random();

    settle();
    repeat (40) @(posedge clk_i);
    $display("Run covered %0d transfers in (%0d ticks, %0d frames incl. broken ones)",
             items_sent, ticks_sent, frames_sent);
    $display("and %0d register writes; %0d results compared, %0d mismatches",
             cfg_writes, reports_ok, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rcfd_pkg.sv
rtl/rcfd_stream_if.sv
rtl/rcfd_ram.sv
rtl/rcfd_ctrl.sv
rtl/rc_frame_decoder_with_lost_watch_top.sv
bench/tb_rc_frame_decoder_with_lost_watch_top.sv
